// ----- sv/bls_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// bls_pkg: shared types and constants for the bounded LIFO stack
// Transaction payloads, operation codes and store dimensions.
// ---------------------------------------------------------------------------
package bls_pkg;

	localparam int DEPTH  = 64;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int CAP_W  = 7;

	localparam logic [1:0] FUNC_PUSH      = 2'd0;
	localparam logic [1:0] FUNC_POP       = 2'd1;
	localparam logic [1:0] FUNC_DUMP_TOP  = 2'd2;
	localparam logic [1:0] FUNC_DUMP_BASE = 2'd3;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

	typedef struct packed {
		logic [1:0]               func;
		logic signed [DATA_W-1:0] push_value;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] out_value;
		logic                     status;
		logic                     last;
	} out_item_t;

endpackage
`default_nettype wire

// ----- sv/bounded_lifo_stack_with_dump.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// bounded_lifo_stack_with_dump: bounded stack of signed words with dumps
// Push, pop and two dump orders over a stack held in a synchronous RAM.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+---------------------
//   input    | in_valid / in_stall        | in_item  (in_item_t)
//   result   | out_valid / out_stall      | out_item (out_item_t)
//   config   | cfg_we                     | cfg_wdata (capacity)
//
// A push leaves the sequencer idle, so a following transaction is accepted right after.
// A pop issues the RAM read, then loads the result register.
// A dump of n entries issues one RAM read per entry.
// Result stalls hold the sequencer; the input is stalled while it is busy.
// Reset clears the fill count and sets the capacity to 64; the RAM is not
// cleared because only written entries are ever read.
// ---------------------------------------------------------------------------
module bounded_lifo_stack_with_dump (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire bls_pkg::in_item_t            in_item,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output bls_pkg::out_item_t                out_item,
	input  wire logic                         cfg_we,
	input  wire logic [bls_pkg::CAP_W-1:0]    cfg_wdata
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic                          state_q;
	logic [bls_pkg::CNT_W-1:0]     fill_q;
	logic [bls_pkg::CAP_W-1:0]     cap_q;
	logic [bls_pkg::CNT_W-1:0]     remain_q;
	logic [bls_pkg::ADDR_W-1:0]    addr_q;
	logic                          down_q;
	logic                          empty_q;
	logic                          out_valid_q;
	bls_pkg::out_item_t            out_q;

	logic                          accept;
	logic                          advance;
	logic                          room;
	logic [bls_pkg::CNT_W-1:0]     limit;
	logic                          ram_we;
	logic                          ram_re;
	logic [bls_pkg::ADDR_W-1:0]    ram_raddr;
	logic [bls_pkg::ADDR_W-1:0]    addr_next;
	logic [bls_pkg::DATA_W-1:0]    ram_rdata;
	logic [bls_pkg::ADDR_W-1:0]    top_addr;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign advance   = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// Capacity values above the store depth saturate to the depth.
	assign limit = (cap_q > bls_pkg::CAP_W'(bls_pkg::DEPTH)) ?
		bls_pkg::CNT_W'(bls_pkg::DEPTH) : bls_pkg::CNT_W'(cap_q);
	assign room  = (fill_q < limit);

	assign top_addr  = bls_pkg::ADDR_W'(fill_q - bls_pkg::CNT_W'(1));
	assign addr_next = down_q ? (addr_q - bls_pkg::ADDR_W'(1)) :
		(addr_q + bls_pkg::ADDR_W'(1));
	assign ram_we    = accept && (in_item.func == bls_pkg::FUNC_PUSH) && room;

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = addr_next;
		if (accept) begin
			ram_raddr = (in_item.func == bls_pkg::FUNC_DUMP_BASE) ?
				'0 : top_addr;
			ram_re    = (in_item.func != bls_pkg::FUNC_PUSH) &&
				(fill_q != '0);
		end else if (advance && !empty_q && (remain_q != bls_pkg::CNT_W'(1))) begin
			ram_re = 1'b1;
		end
	end

	bls_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q[bls_pkg::ADDR_W-1:0]),
		.wdata (in_item.push_value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= bls_pkg::CAP_W'(64);
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
			remain_q    <= '0;
			addr_q      <= '0;
			down_q      <= 1'b0;
			empty_q     <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_item.func)
							bls_pkg::FUNC_PUSH: begin
								if (room) begin
									fill_q <= fill_q + bls_pkg::CNT_W'(1);
								end
							end
							bls_pkg::FUNC_POP: begin
								state_q  <= ST_EMIT;
								remain_q <= bls_pkg::CNT_W'(1);
								addr_q   <= top_addr;
								down_q   <= 1'b1;
								empty_q  <= (fill_q == '0);
								if (fill_q != '0) begin
									fill_q <= fill_q - bls_pkg::CNT_W'(1);
								end
							end
							default: begin
								// An empty dump produces no transaction.
								if (fill_q != '0) begin
									state_q  <= ST_EMIT;
									remain_q <= fill_q;
									empty_q  <= 1'b0;
									down_q   <= (in_item.func == bls_pkg::FUNC_DUMP_TOP);
									addr_q   <= (in_item.func == bls_pkg::FUNC_DUMP_TOP) ?
										top_addr : '0;
								end
							end
						endcase
					end
				end
				ST_EMIT: begin
					if (advance) begin
						if (empty_q || (remain_q == bls_pkg::CNT_W'(1))) begin
							state_q <= ST_IDLE;
						end else begin
							remain_q <= remain_q - bls_pkg::CNT_W'(1);
							addr_q   <= addr_next;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.out_value <= empty_q ? '1 : ram_rdata;
			out_q.status    <= empty_q ? bls_pkg::STATUS_EMPTY : bls_pkg::STATUS_OK;
			out_q.last      <= empty_q || (remain_q == bls_pkg::CNT_W'(1));
		end
	end

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= bls_pkg::CNT_W'(bls_pkg::DEPTH))
		else $error("fill count beyond store depth");

	a_full_push_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (in_item.func == bls_pkg::FUNC_PUSH) && !room)
		|=> (fill_q == $past(fill_q)))
		else $error("push into a full stack changed the fill count");

	a_pop_decrements: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (in_item.func == bls_pkg::FUNC_POP) && (fill_q != '0))
		|=> (fill_q == $past(fill_q) - bls_pkg::CNT_W'(1)))
		else $error("pop of a non-empty stack did not decrement the fill count");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !empty_q && (remain_q != bls_pkg::CNT_W'(1)))
		|=> ((state_q == ST_EMIT) && out_valid_q && !out_q.last))
		else $error("dump run ended early");

	a_last_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (empty_q || (remain_q == bls_pkg::CNT_W'(1))))
		|=> (!in_stall && out_valid_q && out_q.last))
		else $error("final result did not release the input");
`endif

endmodule
`default_nettype wire

// ----- sv/bls_ram.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// bls_ram: entry store of the stack
// One write port and one read port; read data is registered and holds
// its value until the next read is enabled.
// ---------------------------------------------------------------------------
module bls_ram (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [bls_pkg::ADDR_W-1:0]    waddr,
	input  wire logic [bls_pkg::DATA_W-1:0]    wdata,
	input  wire logic                          re,
	input  wire logic [bls_pkg::ADDR_W-1:0]    raddr,
	output logic      [bls_pkg::DATA_W-1:0]    rdata
);

	logic [bls_pkg::DATA_W-1:0] mem [bls_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire
